// ----- rtl/core/lfpd_pkg.sv -----
// shared types, constants and codes of the line follower pd controller
`timescale 1ns / 1ps
`default_nettype none

package lfpd_pkg;

  // sensor array and steering constants
  localparam int unsigned SENSOR_COUNT    = 5;
  localparam int unsigned CENTER_POSITION = 3;
  localparam int unsigned STABLE_NEEDED   = 5;

  // field and port widths
  localparam int unsigned IR_W       = 10;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIN_SPEED     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT    = 3'd5;

  // action codes reported with each result
  localparam logic [1:0] ACT_FOLLOW = 2'd0;
  localparam logic [1:0] ACT_SPIN   = 2'd1;
  localparam logic [1:0] ACT_STOP   = 2'd2;

  // which motor commands the datapath drives out
  typedef enum logic [1:0] {
    EMIT_FOLLOW,
    EMIT_SPIN_RIGHT,
    EMIT_SPIN_LEFT,
    EMIT_STOP
  } emit_kind_e;

  // one scan of raw readings
  typedef struct packed {
    logic [IR_W-1:0] ir_0;
    logic [IR_W-1:0] ir_1;
    logic [IR_W-1:0] ir_2;
    logic [IR_W-1:0] ir_3;
    logic [IR_W-1:0] ir_4;
  } in_item_t;

  // one motor command result
  typedef struct packed {
    logic               left_forward;
    logic [SPEED_W-1:0] left_speed;
    logic               right_forward;
    logic [SPEED_W-1:0] right_speed;
    logic [4:0]         line_bits;
    logic [1:0]         action;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic       scan;
    logic       err;
    logic       mulp;
    logic       muld;
    logic       term;
    logic       acc;
    logic       div;
    logic       sat;
    logic       emit;
    emit_kind_e kind;
  } lfpd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [4:0] line_bits;
    logic       out_free;
  } lfpd_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/line_follower_pd_controller.sv -----
// Line follower pd controller: one scan in, at most one motor command out.
// A follow step runs the pd sequence in turn (error, two gain multiplies, sum,
// smoothing, divide, saturate, drive); spin or stop goes from decide straight to drive,
// and a scan without result returns to idle. A new scan is taken only once the last
// one is done. A waiting result holds the next scan only at drive.
// Reset (async, active low) restores register defaults and clears all follower state.
`timescale 1ns / 1ps
`default_nettype none

module line_follower_pd_controller (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire lfpd_pkg::in_item_t          in_item_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output lfpd_pkg::out_item_t              out_item_o,
  input  wire                              cfg_we_i,
  input  wire [lfpd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [lfpd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  lfpd_pkg::lfpd_cmd_t    cmd;
  lfpd_pkg::lfpd_status_t status;

  // sequencing and mode control
  lfpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic and result register
  lfpd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/lfpd_datapath.sv -----
// datapath: scan binarization, position, pd arithmetic, motor drive and result register
`timescale 1ns / 1ps
`default_nettype none

module lfpd_datapath (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire lfpd_pkg::in_item_t             in_item_i,
  input  wire                                 cfg_we_i,
  input  wire [lfpd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire [lfpd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire lfpd_pkg::lfpd_cmd_t            cmd_i,
  output lfpd_pkg::lfpd_status_t              status_o,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output lfpd_pkg::out_item_t                 out_item_o
);

  // weighted average of the line bits in q3.8, count 3 from a small table, count 5 a constant
  function automatic logic [10:0] calc_pos(input logic [4:0] b);
    logic [3:0]  w;
    logic [2:0]  c;
    logic [10:0] p;
    w = '0;
    c = '0;
    for (int k = 0; k < lfpd_pkg::SENSOR_COUNT; k++) begin
      if (b[k]) begin
        w = w + 4'(k + 1);
        c = c + 3'd1;
      end
    end
    case (c)
      3'd1: p = {w[2:0], 8'd0};
      3'd2: p = {w, 7'd0};
      3'd3: begin
        case (w)
          4'd6:    p = 11'd512;
          4'd7:    p = 11'd597;
          4'd8:    p = 11'd682;
          4'd9:    p = 11'd768;
          4'd10:   p = 11'd853;
          4'd11:   p = 11'd938;
          4'd12:   p = 11'd1024;
          default: p = '0;
        endcase
      end
      3'd4:    p = {1'b0, w, 6'd0};
      3'd5:    p = 11'd768;
      default: p = '0;
    endcase
    return p;
  endfunction

  // signed command to direction bit and clamped magnitude
  function automatic logic [8:0] drive(input logic signed [12:0] c, input logic [7:0] lim);
    logic [12:0] mag;
    logic        fwd;
    fwd = (c > 13'sd0);
    mag = fwd ? 13'(c) : 13'(-c);
    if (mag > {5'b0, lim}) mag = {5'b0, lim};
    return {fwd, mag[7:0]};
  endfunction

  localparam logic signed [12:0] CenterQ88 = 13'(lfpd_pkg::CENTER_POSITION * 256);

  // configuration registers
  logic [9:0] thr_q;
  logic [7:0] prop_q, deriv_q, base_q, spin_q, limit_q;

  // persistent follower state
  logic [10:0]        line_pos_q;
  logic signed [10:0] prev_err_q;
  logic signed [11:0] pd_q;

  // per item working registers
  lfpd_pkg::in_item_t ir_q;
  logic [4:0]         bits_q;
  logic [10:0]        pos_calc_q;
  logic signed [10:0] err_q;
  logic signed [19:0] prod_p_q;
  logic signed [20:0] prod_d_q;
  logic signed [21:0] term_q;
  logic signed [24:0] acc_q;
  logic [11:0]        quot_q;
  logic               neg_q;

  // result register
  lfpd_pkg::out_item_t out_q;
  logic                out_valid_q;

  // binarize the captured scan
  logic [4:0] bits_d;
  assign bits_d = {ir_q.ir_4 <= thr_q, ir_q.ir_3 <= thr_q, ir_q.ir_2 <= thr_q,
                   ir_q.ir_1 <= thr_q, ir_q.ir_0 <= thr_q};

  // position error, saturated to 11 bits
  logic [10:0]        pos_now;
  logic signed [12:0] pos_diff;
  logic signed [10:0] err_d;
  assign pos_now  = (bits_q != 5'd0) ? pos_calc_q : line_pos_q;
  assign pos_diff = CenterQ88 - $signed({2'b0, pos_now});
  always_comb begin
    if (pos_diff < -13'sd1024)     err_d = -11'sd1024;
    else if (pos_diff > 13'sd1023) err_d = 11'sd1023;
    else                           err_d = pos_diff[10:0];
  end

  // gain products
  logic signed [19:0] prod_p_d;
  logic signed [11:0] err_delta;
  logic signed [20:0] prod_d_d;
  assign prod_p_d  = 20'(err_q) * 20'($signed({1'b0, prop_q}));
  assign err_delta = 12'(err_q) - 12'(prev_err_q);
  assign prod_d_d  = 21'(err_delta) * 21'($signed({1'b0, deriv_q}));

  // smoothing numerator 7*term + 768*pd
  logic signed [24:0] term_x, pd_x, acc_d;
  assign term_x = 25'(term_q);
  assign pd_x   = 25'(pd_q);
  assign acc_d  = (term_x <<< 3) - term_x + (pd_x <<< 9) + (pd_x <<< 8);

  // divide magnitude by 2560: shift by 512, then reciprocal multiply by 1/5
  logic [23:0] acc_mag;
  logic [30:0] quot_prod;
  assign acc_mag   = acc_q[24] ? 24'(-acc_q) : 24'(acc_q);
  assign quot_prod = {17'b0, acc_mag[22:9]} * 31'd52429;

  // restore sign and saturate to 12 bits
  logic signed [12:0] quot_s, pd_new;
  logic signed [11:0] pd_sat;
  assign quot_s = $signed({1'b0, quot_q});
  assign pd_new = neg_q ? -quot_s : quot_s;
  always_comb begin
    if (pd_new > 13'sd2047)       pd_sat = 12'sd2047;
    else if (pd_new < -13'sd2048) pd_sat = -12'sd2048;
    else                          pd_sat = pd_new[11:0];
  end

  // motor commands for the selected result kind
  logic signed [12:0] base_x, pd_e, spin_x, half_x, cmd_l, cmd_r;
  logic [8:0]         drv_l, drv_r;
  logic [1:0]         act;
  assign base_x = $signed({5'b0, base_q});
  assign pd_e   = 13'(pd_q);
  assign spin_x = $signed({5'b0, spin_q});
  assign half_x = $signed({6'b0, spin_q[7:1]});
  always_comb begin
    unique case (cmd_i.kind)
      lfpd_pkg::EMIT_FOLLOW: begin
        cmd_l = base_x - pd_e;
        cmd_r = base_x + pd_e;
        act   = lfpd_pkg::ACT_FOLLOW;
      end
      lfpd_pkg::EMIT_SPIN_RIGHT: begin
        cmd_l = spin_x;
        cmd_r = -half_x;
        act   = lfpd_pkg::ACT_SPIN;
      end
      lfpd_pkg::EMIT_SPIN_LEFT: begin
        cmd_l = -half_x;
        cmd_r = spin_x;
        act   = lfpd_pkg::ACT_SPIN;
      end
      default: begin
        cmd_l = '0;
        cmd_r = '0;
        act   = lfpd_pkg::ACT_STOP;
      end
    endcase
  end
  assign drv_l = drive(cmd_l, limit_q);
  assign drv_r = drive(cmd_r, limit_q);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= 10'd500;
      prop_q  <= 8'd40;
      deriv_q <= 8'd0;
      base_q  <= 8'd225;
      spin_q  <= 8'd175;
      limit_q <= 8'd250;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lfpd_pkg::CFG_LINE_THRESHOLD: thr_q   <= cfg_data_i;
        lfpd_pkg::CFG_PROP_GAIN:      prop_q  <= cfg_data_i[7:0];
        lfpd_pkg::CFG_DERIV_GAIN:     deriv_q <= cfg_data_i[7:0];
        lfpd_pkg::CFG_BASE_SPEED:     base_q  <= cfg_data_i[7:0];
        lfpd_pkg::CFG_SPIN_SPEED:     spin_q  <= cfg_data_i[7:0];
        lfpd_pkg::CFG_SPEED_LIMIT:    limit_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // follower state that survives between items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_pos_q <= '0;
      prev_err_q <= '0;
      pd_q       <= '0;
    end else begin
      if (cmd_i.err) line_pos_q <= pos_now;
      if (cmd_i.sat) begin
        pd_q       <= pd_sat;
        prev_err_q <= err_q;
      end
    end
  end

  // working pipeline registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) ir_q <= in_item_i;
    if (cmd_i.scan) begin
      bits_q     <= bits_d;
      pos_calc_q <= calc_pos(bits_d);
    end
    if (cmd_i.err)  err_q    <= err_d;
    if (cmd_i.mulp) prod_p_q <= prod_p_d;
    if (cmd_i.muld) prod_d_q <= prod_d_d;
    if (cmd_i.term) term_q   <= 22'(prod_p_q) + 22'(prod_d_q);
    if (cmd_i.acc)  acc_q    <= acc_d;
    if (cmd_i.div) begin
      quot_q <= quot_prod[29:18];
      neg_q  <= acc_q[24];
    end
    if (cmd_i.emit) begin
      out_q.left_forward  <= drv_l[8];
      out_q.left_speed    <= drv_l[7:0];
      out_q.right_forward <= drv_r[8];
      out_q.right_speed   <= drv_r[7:0];
      out_q.line_bits     <= bits_q;
      out_q.action        <= act;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_item_o         = out_q;
  assign status_o.line_bits = bits_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

// ----- rtl/core/lfpd_ctrl.sv -----
// controller: run mode, turn memory, stable count and the per item sequence
`timescale 1ns / 1ps
`default_nettype none

module lfpd_ctrl (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire lfpd_pkg::lfpd_status_t status_i,
  output lfpd_pkg::lfpd_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_ERR,
    ST_MULP,
    ST_MULD,
    ST_TERM,
    ST_ACC,
    ST_DIV,
    ST_SAT,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    MODE_FOLLOW,
    MODE_SEARCH,
    MODE_CHECK,
    MODE_STOPPED
  } mode_e;

  typedef enum logic [1:0] {
    TURN_NONE,
    TURN_LEFT,
    TURN_RIGHT
  } turn_e;

  state_e                 state_q;
  mode_e                  mode_q;
  turn_e                  turn_q;
  logic [2:0]             stable_q;
  lfpd_pkg::emit_kind_e   kind_q;

  // scan classification
  logic [4:0] bits;
  logic       all_line, no_line, stable_hit;
  logic [2:0] stable_next;
  assign bits        = status_i.line_bits;
  assign all_line    = &bits;
  assign no_line     = ~|bits;
  assign stable_hit  = bits[3] && (!bits[2] || !bits[4]);
  assign stable_next = stable_hit ? stable_q + 3'd1 : 3'd0;

  // sequence and mode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mode_q   <= MODE_FOLLOW;
      turn_q   <= TURN_NONE;
      stable_q <= '0;
      kind_q   <= lfpd_pkg::EMIT_FOLLOW;
    end else begin
      case (state_q)
        ST_IDLE:  if (in_valid_i) state_q <= ST_SCAN;
        ST_SCAN:  state_q <= ST_DECIDE;
        ST_DECIDE: begin
          state_q <= ST_IDLE;
          unique case (mode_q)
            MODE_SEARCH: begin
              if (stable_next >= 3'(lfpd_pkg::STABLE_NEEDED)) begin
                stable_q <= '0;
                turn_q   <= TURN_NONE;
                mode_q   <= MODE_FOLLOW;
              end else begin
                stable_q <= stable_next;
              end
            end
            MODE_CHECK: begin
              if (all_line) begin
                mode_q  <= MODE_STOPPED;
                kind_q  <= lfpd_pkg::EMIT_STOP;
                state_q <= ST_EMIT;
              end else begin
                if (no_line) turn_q <= TURN_RIGHT;
                mode_q <= MODE_FOLLOW;
              end
            end
            MODE_STOPPED: begin
              if (!all_line) mode_q <= MODE_FOLLOW;
            end
            MODE_FOLLOW: begin
              if (no_line && turn_q != TURN_NONE) begin
                // line lost: spin toward the remembered side
                mode_q   <= MODE_SEARCH;
                stable_q <= '0;
                kind_q   <= (turn_q == TURN_RIGHT) ? lfpd_pkg::EMIT_SPIN_RIGHT
                                                   : lfpd_pkg::EMIT_SPIN_LEFT;
                state_q  <= ST_EMIT;
              end else begin
                kind_q  <= lfpd_pkg::EMIT_FOLLOW;
                state_q <= ST_ERR;
                // edge memory and all-line detection
                if (bits[0] && !bits[4]) turn_q <= TURN_LEFT;
                if (bits[4] && !bits[0]) turn_q <= TURN_RIGHT;
                else if (all_line)       mode_q <= MODE_CHECK;
              end
            end
          endcase
        end
        ST_ERR:  state_q <= ST_MULP;
        ST_MULP: state_q <= ST_MULD;
        ST_MULD: state_q <= ST_TERM;
        ST_TERM: state_q <= ST_ACC;
        ST_ACC:  state_q <= ST_DIV;
        ST_DIV:  state_q <= ST_SAT;
        ST_SAT:  state_q <= ST_EMIT;
        ST_EMIT: if (status_i.out_free) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = kind_q;
    case (state_q)
      ST_IDLE:  cmd_o.capture = in_valid_i;
      ST_SCAN:  cmd_o.scan    = 1'b1;
      ST_ERR:   cmd_o.err     = 1'b1;
      ST_MULP:  cmd_o.mulp    = 1'b1;
      ST_MULD:  cmd_o.muld    = 1'b1;
      ST_TERM:  cmd_o.term    = 1'b1;
      ST_ACC:   cmd_o.acc     = 1'b1;
      ST_DIV:   cmd_o.div     = 1'b1;
      ST_SAT:   cmd_o.sat     = 1'b1;
      ST_EMIT:  cmd_o.emit    = status_i.out_free;
      default:  ;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/core/lfpd_checker.sv -----
// port level checks for the line follower pd controller and their bind
`timescale 1ns / 1ps
`default_nettype none

module lfpd_checker (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            in_valid_i,
  input wire                            in_ready_o,
  input wire                            out_valid_o,
  input wire                            out_ready_i,
  input wire lfpd_pkg::out_item_t       out_item_o
);

  // a stalled result holds its valid and payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // one item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted item");

  // a stop result follows an all-line scan and drives nothing
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.action == lfpd_pkg::ACT_STOP |->
      out_item_o.left_speed == 8'd0 && out_item_o.right_speed == 8'd0 &&
      !out_item_o.left_forward && !out_item_o.right_forward &&
      out_item_o.line_bits == 5'h1f)
    else $error("stop result with motion or wrong pattern");

  // a spin starts on an empty scan with the wheels never both forward
  a_spin_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.action == lfpd_pkg::ACT_SPIN |->
      out_item_o.line_bits == 5'h00 &&
      !(out_item_o.left_forward && out_item_o.right_forward))
    else $error("malformed spin result");

endmodule

bind line_follower_pd_controller lfpd_checker u_lfpd_checker (.*);

`default_nettype wire
